### rtl/core/ssp_pkg.sv
package ssp_pkg;

    localparam int ADDR_W  = 16;
    localparam int FIELD_W = 52;
    localparam int DIM_W   = 10;
    localparam int IDX_W   = 32;
    localparam int SEED_W  = 64;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic write;
        logic load;
        logic issue;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic hash_busy;
        logic out_hold;
    } t_sts;

endpackage

### rtl/core/ssp_hash.sv
module ssp_hash
    import ssp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SEED_W-1:0] i_seed,
    output logic              o_busy,
    output logic [SEED_W-1:0] o_hash
);

    localparam logic [2:0] MIX_ADD21 = 3'd0;
    localparam logic [2:0] MIX_XOR24 = 3'd1;
    localparam logic [2:0] MIX_ADD38 = 3'd2;
    localparam logic [2:0] MIX_XOR14 = 3'd3;
    localparam logic [2:0] MIX_ADD24 = 3'd4;
    localparam logic [2:0] MIX_XOR28 = 3'd5;
    localparam logic [2:0] MIX_ADD31 = 3'd6;

    logic [SEED_W-1:0] r_v, n_v;
    logic [2:0]        r_step, n_step;
    logic              r_busy, n_busy;

    always_comb begin
        n_v    = r_v;
        n_step = r_step;
        n_busy = r_busy;
        if (i_start) begin
            n_step = MIX_ADD21;
            n_busy = 1'b1;
        end else if (r_busy) begin
            case (r_step)
                MIX_ADD21: n_v = (~i_seed) + (i_seed << 21);
                MIX_XOR24: n_v = r_v ^ (r_v >> 24);
                MIX_ADD38: n_v = (r_v + (r_v << 3)) + (r_v << 8);
                MIX_XOR14: n_v = r_v ^ (r_v >> 14);
                MIX_ADD24: n_v = (r_v + (r_v << 2)) + (r_v << 4);
                MIX_XOR28: n_v = r_v ^ (r_v >> 28);
                MIX_ADD31: n_v = r_v + (r_v << 31);
                default:   n_v = r_v;
            endcase
            if (r_step == MIX_ADD31) begin
                n_busy = 1'b0;
            end else begin
                n_step = r_step + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= MIX_ADD21;
            r_busy <= 1'b1;
        end else begin
            r_step <= n_step;
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;
    end

    assign o_busy = r_busy;
    assign o_hash = r_v;

endmodule

### rtl/core/ssp_datapath.sv
module ssp_datapath
    import ssp_pkg::*;
#(
    parameter int MATRIX_BITS = 52,
    parameter int DIMENSIONS  = 1024,
    parameter int INDEX_BITS  = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_cfg_we,
    input  logic [SEED_W-1:0]  i_cfg_data,
    input  logic [ADDR_W-1:0]  i_table_address,
    input  logic [FIELD_W-1:0] i_table_word,
    input  logic [IDX_W-1:0]   i_point_index,
    input  logic [DIM_W-1:0]   i_dimension,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [FIELD_W-1:0] o_sample_fraction,
    output logic [DIM_W-1:0]   o_sample_dimension
);

    localparam int WORD_W      = (MATRIX_BITS < FIELD_W) ? MATRIX_BITS : FIELD_W;
    localparam int TABLE_DEPTH = DIMENSIONS * MATRIX_BITS;
    localparam int MEM_DEPTH   = (TABLE_DEPTH < (1 << ADDR_W)) ? TABLE_DEPTH : (1 << ADDR_W);
    localparam int MEM_AW      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    logic [WORD_W-1:0] r_mem [MEM_DEPTH];

    logic [SEED_W-1:0]     r_seed;
    logic                  w_hash_busy;
    logic [SEED_W-1:0]     w_hash;
    logic [INDEX_BITS-1:0] r_index;
    logic [ADDR_W-1:0]     r_slot;
    logic [DIM_W-1:0]      r_dim;
    logic [WORD_W-1:0]     r_acc;
    logic [WORD_W-1:0]     r_rdata;
    logic                  r_use;
    logic                  r_pend;
    logic                  r_out_valid;
    logic [WORD_W-1:0]     r_out_frac;
    logic [DIM_W-1:0]      r_out_dim;

    ssp_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg_we),
        .i_seed  (r_seed),
        .o_busy  (w_hash_busy),
        .o_hash  (w_hash)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.write && (32'(i_table_address) < TABLE_DEPTH)) begin
            r_mem[i_table_address[MEM_AW-1:0]] <= i_table_word[WORD_W-1:0];
        end
        if (i_cmd.issue) begin
            r_rdata <= r_mem[r_slot[MEM_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_data;
            end
            r_pend <= i_cmd.issue;
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_index <= i_point_index[INDEX_BITS-1:0];
            r_slot  <= ADDR_W'(16'(i_dimension) * 16'(MATRIX_BITS));
            r_dim   <= i_dimension;
            r_acc   <= w_hash[WORD_W-1:0];
        end else begin
            if (i_cmd.issue) begin
                r_index <= r_index >> 1;
                r_slot  <= r_slot + ADDR_W'(1);
                r_use   <= r_index[0] && (32'(r_slot) < TABLE_DEPTH);
            end
            if (r_pend && r_use) begin
                r_acc <= r_acc ^ r_rdata;
            end
        end
        if (i_cmd.finish) begin
            r_out_frac <= r_acc;
            r_out_dim  <= r_dim;
        end
    end

    assign o_sts.hash_busy  = w_hash_busy;
    assign o_sts.out_hold   = r_out_valid && i_out_stall;
    assign o_out_valid        = r_out_valid;
    assign o_sample_fraction  = FIELD_W'(r_out_frac);
    assign o_sample_dimension = r_out_dim;

endmodule

### rtl/core/ssp_ctrl.sv
module ssp_ctrl
    import ssp_pkg::*;
#(
    parameter int INDEX_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_operation,
    input  logic i_cfg_valid,
    input  t_sts i_sts,
    output logic o_in_stall,
    output logic o_cfg_ready,
    output t_cmd o_cmd
);

    localparam int BIT_W = (INDEX_BITS > 1) ? $clog2(INDEX_BITS) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic             w_accept;

    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_in_stall  = (r_state != ST_IDLE) || i_sts.hash_busy || i_cfg_valid;
    assign w_accept    = i_in_valid && !o_in_stall;

    always_comb begin
        n_state      = r_state;
        n_bit        = r_bit;
        o_cmd.write  = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.issue  = 1'b0;
        o_cmd.finish = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_operation == OP_WRITE) begin
                        o_cmd.write = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_bit      = '0;
                        n_state    = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                o_cmd.issue = 1'b1;
                if (r_bit == BIT_W'(INDEX_BITS - 1)) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_bit = r_bit + BIT_W'(1);
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!i_sts.out_hold) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
        end
    end

`ifndef SYNTHESIS
    a_no_hash_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !i_sts.hash_busy)
        else $error("hash rerun while a sample is in work");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> !i_sts.out_hold)
        else $error("result overwrites a held word");

    a_sample_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_RUN) && (r_bit == '0))
        else $error("sample did not start its bit walk");

    a_drain_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> ($past(r_state) == ST_RUN))
        else $error("drain entered out of order");
`endif

endmodule

### rtl/core/scrambled_sobol_point_core.sv
// Sample word: accept, INDEX_BITS table reads through the single table read port, a drain
// state, then the result goes to the output register once no result is held there.
// Table write word: no result. The result register lets a new word enter
// while the previous result is still held.
// Reset (synchronous, active low) clears the seed to 0 and runs the seed hash. Input stalls
// while a hash runs (after reset or a seed write) or i_cfg_valid is high. Table is not cleared.
module scrambled_sobol_point_core
    import ssp_pkg::*;
#(
    parameter int MATRIX_BITS = 52,
    parameter int DIMENSIONS  = 1024,
    parameter int INDEX_BITS  = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [SEED_W-1:0]  i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_operation,
    input  logic [ADDR_W-1:0]  i_table_address,
    input  logic [FIELD_W-1:0] i_table_word,
    input  logic [IDX_W-1:0]   i_point_index,
    input  logic [DIM_W-1:0]   i_dimension,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [FIELD_W-1:0] o_sample_fraction,
    output logic [DIM_W-1:0]   o_sample_dimension
);

    t_cmd w_cmd;
    t_sts w_sts;

    ssp_ctrl #(
        .INDEX_BITS (INDEX_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_cfg_valid (i_cfg_valid),
        .i_sts       (w_sts),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (w_cmd)
    );

    ssp_datapath #(
        .MATRIX_BITS (MATRIX_BITS),
        .DIMENSIONS  (DIMENSIONS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_cfg_we           (i_cfg_valid && o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .i_table_address    (i_table_address),
        .i_table_word       (i_table_word),
        .i_point_index      (i_point_index),
        .i_dimension        (i_dimension),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_sample_fraction  (o_sample_fraction),
        .o_sample_dimension (o_sample_dimension)
    );

endmodule
